/* sv/alc_pkg.sv */
// Shared types, character codes and limits of the ASCII line calculator.
package alc_pkg;

    localparam int LINE_LIMIT = 512;
    localparam int LEN_W      = $clog2(LINE_LIMIT + 1);
    localparam int DIV_W      = 32;
    localparam int CNT_W      = $clog2(DIV_W);

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_MUL   = 8'h2A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DIV   = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_PARSE   = 3'd1,
        ST_MISSING = 3'd2,
        ST_DIV0    = 3'd3,
        ST_LONG    = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        OP_NONE = 3'd0,
        OP_MUL  = 3'd1,
        OP_ADD  = 3'd2,
        OP_SUB  = 3'd3,
        OP_DIV  = 3'd4
    } t_op;

    typedef struct packed {
        logic byte_en;
        logic latch;
        logic exec;
        logic div_step;
        logic div_fix;
    } t_cmd;

    typedef struct packed {
        logic line_end;
        logic need_div;
        logic div_last;
    } t_sts;

endpackage

/* sv/alc_ctrl.sv */
// Controller state machine of the ASCII line calculator.
module alc_ctrl
    import alc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    output logic o_valid,
    input  logic i_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EXEC = 5'b00010,
        S_DIV  = 5'b00100,
        S_FIX  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = 1'b1;
        o_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    if (i_sts.line_end) begin
                        o_cmd.latch = 1'b1;
                        n_state     = S_EXEC;
                    end else begin
                        o_cmd.byte_en = 1'b1;
                    end
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_sts.need_div ? S_DIV : S_OUT;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_FIX;
                end
            end
            S_FIX: begin
                o_cmd.div_fix = 1'b1;
                n_state       = S_OUT;
            end
            S_OUT: begin
                o_valid = 1'b1;
                if (!i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_line_end_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_valid && i_sts.line_end) |=> r_state == S_EXEC)
        else $error("line end did not start evaluation");

    a_div_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.exec && i_sts.need_div) |=> r_state == S_DIV)
        else $error("divide not started");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.latch || o_cmd.byte_en) |-> !o_valid)
        else $error("word accepted while result pending");

endmodule

/* sv/alc_datapath.sv */
// Datapath of the ASCII line calculator: token parser, arithmetic and divider.
module alc_datapath
    import alc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [7:0]  i_char_in,
    input  logic        i_end_of_input,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    output logic [31:0] o_answer,
    output logic [2:0]  o_status
);

    typedef struct packed {
        logic [31:0] acc;
        logic        neg;
        logic        stopped;
        logic        sign_ok;
    } t_num;

    function automatic t_num feed(input t_num s, input logic [7:0] c);
        t_num        r;
        logic [31:0] d;
        logic [31:0] x10;
        r   = s;
        d   = {24'd0, c - CH_ZERO};
        x10 = (s.acc << 3) + (s.acc << 1);
        if (s.stopped) begin
            r = s;
        end else if (s.sign_ok && c >= CH_VT && c <= CH_CR) begin
            r = s;
        end else if (s.sign_ok && (c == CH_PLUS || c == CH_MINUS)) begin
            r.sign_ok = 1'b0;
            r.neg     = (c == CH_MINUS);
        end else if (c >= CH_ZERO && c <= CH_NINE) begin
            r.sign_ok = 1'b0;
            r.acc     = s.neg ? x10 - d : x10 + d;
        end else begin
            r.stopped = 1'b1;
        end
        return r;
    endfunction

    // parser state
    logic [1:0]       r_tc, n_tc;
    logic             r_inside, n_inside;
    logic [31:0]      r_first, n_first;
    logic [31:0]      r_second, n_second;
    logic             r_neg, n_neg;
    logic             r_stopped, n_stopped;
    logic             r_sign_ok, n_sign_ok;
    logic [7:0]       r_op, n_op;
    logic             r_too_long, n_too_long;
    logic [LEN_W-1:0] r_len, n_len;
    logic             r_ovf, n_ovf;

    // evaluation
    logic [31:0]      r_a, r_b;
    t_status          r_status, n_status;
    t_op              r_kind, n_kind;
    logic [31:0]      r_rem, r_quo, r_den;
    logic             r_qneg;
    logic [CNT_W-1:0] r_cnt;
    logic [31:0]      r_answer;

    t_num  w_fin, w_fout;
    logic  w_feed;
    logic  w_to_first;
    logic  w_sep;
    logic [32:0] w_shift, w_diff;

    assign w_sep = (i_char_in == CH_SP) || (i_char_in == CH_TAB) || (i_char_in == CH_NUL);
    assign w_fout = feed(w_fin, i_char_in);

    always_comb begin
        n_tc       = r_tc;
        n_inside   = r_inside;
        n_first    = r_first;
        n_second   = r_second;
        n_neg      = r_neg;
        n_stopped  = r_stopped;
        n_sign_ok  = r_sign_ok;
        n_op       = r_op;
        n_too_long = r_too_long;
        n_len      = r_len;
        n_ovf      = r_ovf;
        w_feed     = 1'b0;
        w_to_first = (r_tc == 2'd1);
        w_fin      = {(w_to_first ? r_first : r_second), r_neg, r_stopped, r_sign_ok};

        if (r_len < LEN_W'(LINE_LIMIT)) begin
            n_len = r_len + LEN_W'(1);
        end
        if (n_len >= LEN_W'(LINE_LIMIT)) begin
            n_ovf = 1'b1;
        end

        if (w_sep) begin
            n_inside = 1'b0;
        end else if (!r_inside) begin
            n_inside = 1'b1;
            if (r_tc != 2'd3) begin
                n_tc      = r_tc + 2'd1;
                n_neg     = 1'b0;
                n_stopped = 1'b0;
                n_sign_ok = 1'b1;
                if (n_tc == 2'd2) begin
                    n_op = i_char_in;
                end else begin
                    w_to_first = (n_tc == 2'd1);
                    w_fin      = {(w_to_first ? r_first : r_second), 1'b0, 1'b0, 1'b1};
                    w_feed     = 1'b1;
                end
            end else begin
                n_stopped = 1'b1;
            end
        end else if (r_tc == 2'd2) begin
            n_too_long = 1'b1;
        end else begin
            w_feed = 1'b1;
        end

        if (w_feed) begin
            n_neg     = w_fout.neg;
            n_stopped = w_fout.stopped;
            n_sign_ok = w_fout.sign_ok;
            if (w_to_first) begin
                n_first = w_fout.acc;
            end else begin
                n_second = w_fout.acc;
            end
        end
    end

    always_comb begin
        n_kind   = OP_NONE;
        n_status = ST_OK;
        if (r_ovf) begin
            n_status = ST_LONG;
        end else if (r_tc != 2'd3) begin
            n_status = ST_MISSING;
        end else if (r_too_long) begin
            n_status = ST_PARSE;
        end else begin
            case (r_op)
                CH_MUL:   n_kind = OP_MUL;
                CH_PLUS:  n_kind = OP_ADD;
                CH_MINUS: n_kind = OP_SUB;
                CH_DIV: begin
                    n_kind = OP_DIV;
                    if (r_second == 32'd0) begin
                        n_status = ST_DIV0;
                    end
                end
                default:  n_status = ST_PARSE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.latch) begin
            r_tc       <= 2'd0;
            r_inside   <= 1'b0;
            r_first    <= 32'd0;
            r_second   <= 32'd0;
            r_neg      <= 1'b0;
            r_stopped  <= 1'b0;
            r_sign_ok  <= 1'b1;
            r_op       <= 8'd0;
            r_too_long <= 1'b0;
            r_len      <= '0;
            r_ovf      <= 1'b0;
        end else if (i_cmd.byte_en) begin
            r_tc       <= n_tc;
            r_inside   <= n_inside;
            r_first    <= n_first;
            r_second   <= n_second;
            r_neg      <= n_neg;
            r_stopped  <= n_stopped;
            r_sign_ok  <= n_sign_ok;
            r_op       <= n_op;
            r_too_long <= n_too_long;
            r_len      <= n_len;
            r_ovf      <= n_ovf;
        end
    end

    // restoring divider on magnitudes
    assign w_shift = {r_rem, r_quo[31]};
    assign w_diff  = w_shift - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_a      <= r_first;
            r_b      <= r_second;
            r_status <= n_status;
            r_kind   <= n_kind;
        end
        if (i_cmd.exec) begin
            r_rem  <= 32'd0;
            r_quo  <= r_a[31] ? 32'd0 - r_a : r_a;
            r_den  <= r_b[31] ? 32'd0 - r_b : r_b;
            r_qneg <= r_a[31] ^ r_b[31];
            if (r_status != ST_OK) begin
                r_answer <= 32'd0;
            end else begin
                case (r_kind)
                    OP_MUL:  r_answer <= r_a * r_b;
                    OP_ADD:  r_answer <= r_a + r_b;
                    OP_SUB:  r_answer <= r_a - r_b;
                    default: r_answer <= 32'd0;
                endcase
            end
        end
        if (i_cmd.div_step) begin
            if (!w_diff[32]) begin
                r_rem <= w_diff[31:0];
                r_quo <= {r_quo[30:0], 1'b1};
            end else begin
                r_rem <= w_shift[31:0];
                r_quo <= {r_quo[30:0], 1'b0};
            end
        end
        if (i_cmd.div_fix) begin
            r_answer <= r_qneg ? 32'd0 - r_quo : r_quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.exec) begin
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_cnt <= r_cnt + CNT_W'(1);
        end
    end

    assign o_sts.line_end = i_end_of_input || (i_char_in == CH_NL);
    assign o_sts.need_div = (r_kind == OP_DIV) && (r_status == ST_OK);
    assign o_sts.div_last = (r_cnt == CNT_W'(DIV_W - 1));
    assign o_answer       = r_answer;
    assign o_status       = r_status;

    a_latch_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.latch |=> (r_tc == 2'd0 && r_len == '0 && !r_ovf))
        else $error("parser not cleared at line end");

    a_fix_after_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_fix |-> ($past(i_cmd.div_step) && r_cnt == '0))
        else $error("quotient fixed before all steps");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_len >= LEN_W'(LINE_LIMIT)) |-> r_ovf)
        else $error("length limit reached without overflow flag");

endmodule

/* sv/ascii_line_calculator.sv */
// Top level of the ASCII line calculator.
// Evaluates one line "A op B" sent as ASCII words, one byte per word, ended by newline or
// i_end_of_input; A and B are atoi-style decimals wrapping mod 2^32, op is one of * / + -.
// Ordinary bytes are taken one per cycle. The answer/status word is offered after the line
// end is taken and the evaluate state (+ - * and errors) or the evaluate, divide and sign-fix
// states (divide; one quotient bit per cycle in the restoring divider) have run; new bytes are
// held off until that word is taken. Lines of LINE_LIMIT (512) or more bytes report status 4.
module ascii_line_calculator
    import alc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_char_in,
    input  logic        i_end_of_input,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_answer,
    output logic [2:0]  o_status
);

    t_cmd w_cmd;
    t_sts w_sts;

    alc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    alc_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_char_in      (i_char_in),
        .i_end_of_input (i_end_of_input),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .o_answer       (o_answer),
        .o_status       (o_status)
    );

endmodule
